@@ design/tst_pkg.sv @@
// ----------------------------------------------------------------------------
// tst_pkg: shared types and codes for the timer slot table
// Command codes, result kinds, slot status codes and the operand word of the
// shared add/subtract unit.
// ----------------------------------------------------------------------------
package tst_pkg;

  // field widths
  localparam int DATA_W      = 16;
  localparam int SLOT_ID_W   = 3;
  localparam int CMD_W       = 2;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;

  // only slots with a 3-bit id can be addressed
  localparam int ADDRESSABLE = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACK      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;

  // slot status codes
  localparam logic [STATUS_W-1:0] ST_UNASSIGNED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STOPPED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RUNNING    = 2'd2;

  // request to the shared add/subtract unit
  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              sub;
  } addsub_req_t;

endpackage

@@ design/timer_slot_table.sv @@
// ----------------------------------------------------------------------------
// timer_slot_table: table of software timer slots
// A command is taken when start is high and busy is low. Register and tick
// scan the slots one per cycle through a small sequencer, tick pausing for
// a re-arm step after each timer that fires; one shared add/subtract unit
// does the expiry test, the re-arm and the start deadline. Start and stop
// run a single execute step; register scans until it finds an unassigned
// slot or reaches the last; tick scans all S = min(NUM_TIMERS, 8) slots,
// re-arming each timer that fires, and then a finish step sends the last
// word. Each result word appears on the out_ ports for exactly one cycle
// with out_valid high and must be taken then: there is no way to hold
// results off. The final result of a command shows out_last high, and
// appears in the same cycle that busy drops.
// ----------------------------------------------------------------------------
module timer_slot_table import tst_pkg::*; #(
  parameter int NUM_TIMERS    = 8,
  parameter int EXPIRY_WINDOW = 32768
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [SLOT_ID_W-1:0] in_timer_id,
  input  logic [DATA_W-1:0]    in_duration,
  input  logic                 in_repeat_flag,
  input  logic [DATA_W-1:0]    in_event_id,
  output logic                 out_valid,
  output logic [KIND_W-1:0]    out_result_kind,
  output logic [SLOT_ID_W-1:0] out_slot_id,
  output logic [DATA_W-1:0]    out_fired_event,
  output logic                 out_register_failed,
  output logic [DATA_W-1:0]    out_system_time,
  output logic                 out_last
);

  localparam int SLOTS  = (NUM_TIMERS < ADDRESSABLE) ? NUM_TIMERS : ADDRESSABLE;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DIFF_W = DATA_W + 1;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [DIFF_W-1:0] WINDOW   = DIFF_W'(EXPIRY_WINDOW);
  localparam logic [SLOT_ID_W:0] SLOT_LIMIT = (SLOT_ID_W+1)'(SLOTS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_REARM  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r;
  logic [SLOT_ID_W-1:0]  id_r;
  logic [DATA_W-1:0]     dur_r;
  logic                  rep_r;
  logic [DATA_W-1:0]     ev_r;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [DATA_W-1:0]     now_r, now_nxt;

  logic [STATUS_W-1:0]   status_r   [SLOTS];
  logic [DATA_W-1:0]     deadline_r [SLOTS];
  logic [DATA_W-1:0]     period_r   [SLOTS];
  logic [DATA_W-1:0]     event_r    [SLOTS];

  logic                  pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]      pend_slot_r, pend_slot_nxt;
  logic [DATA_W-1:0]     pend_event_r, pend_event_nxt;

  logic                  out_valid_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic [SLOT_ID_W-1:0]  out_slot_r;
  logic [DATA_W-1:0]     out_event_r;
  logic                  out_failed_r;
  logic                  out_last_r;

  logic                  emit;
  logic [KIND_W-1:0]     emit_kind;
  logic [SLOT_ID_W-1:0]  emit_slot;
  logic [DATA_W-1:0]     emit_event;
  logic                  emit_failed;
  logic                  emit_last;

  logic                  st_we;
  logic [STATUS_W-1:0]   st_wdata;
  logic                  dl_we;
  logic                  arm_we;
  logic [IDX_W-1:0]      wr_idx;

  logic                  accept;
  logic                  id_ok;
  logic [IDX_W-1:0]      id_idx;
  logic                  fires;
  addsub_req_t           alu_req;
  logic [DIFF_W-1:0]     alu_sum;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign id_ok  = ({1'b0, id_r} < SLOT_LIMIT);
  assign id_idx = id_r[IDX_W-1:0];

  // operand select for the shared unit
  always_comb begin
    alu_req.a   = now_r;
    alu_req.b   = dur_r;
    alu_req.sub = 1'b0;
    case (state_r)
      S_SCAN: begin
        alu_req.b   = deadline_r[idx_r];
        alu_req.sub = 1'b1;
      end
      S_REARM: begin
        alu_req.b = period_r[idx_r];
      end
      default: begin
        alu_req.b = dur_r;
      end
    endcase
  end

  tst_addsub u_addsub (
    .req (alu_req),
    .sum (alu_sum)
  );

  // expiry test: difference inside the window and no borrow (now >= deadline)
  assign fires = (status_r[idx_r] == ST_RUNNING) &&
                 ({1'b0, alu_sum[DATA_W-1:0]} < WINDOW) && alu_sum[DATA_W];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    now_nxt        = now_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    pend_event_nxt = pend_event_r;
    emit           = 1'b0;
    emit_kind      = KIND_ACK;
    emit_slot      = '0;
    emit_event     = '0;
    emit_failed    = 1'b0;
    emit_last      = 1'b0;
    st_we          = 1'b0;
    st_wdata       = ST_STOPPED;
    dl_we          = 1'b0;
    arm_we         = 1'b0;
    wr_idx         = idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt        = '0;
          pend_valid_nxt = 1'b0;
          case (in_command)
            CMD_REGISTER: state_nxt = S_SCAN;
            CMD_TICK: begin
              state_nxt = S_SCAN;
              now_nxt   = now_r + 1'b1;
            end
            default: state_nxt = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        wr_idx    = id_idx;
        if (id_ok) begin
          if (cmd_r == CMD_START) begin
            if (status_r[id_idx] == ST_STOPPED) begin
              st_we    = 1'b1;
              st_wdata = ST_RUNNING;
              dl_we    = 1'b1;
              arm_we   = 1'b1;
            end
          end else begin
            st_we = 1'b1;
          end
        end
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (cmd_r == CMD_REGISTER) begin
          // first unassigned slot wins
          if (status_r[idx_r] == ST_UNASSIGNED) begin
            st_we     = 1'b1;
            emit      = 1'b1;
            emit_kind = KIND_REGISTER;
            emit_slot = SLOT_ID_W'(idx_r);
            emit_last = 1'b1;
            state_nxt = S_IDLE;
          end else if (idx_r == LAST_IDX) begin
            emit        = 1'b1;
            emit_kind   = KIND_REGISTER;
            emit_failed = 1'b1;
            emit_last   = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          // tick: hold each fired word back until the next one is known
          if (fires) begin
            if (pend_valid_r) begin
              emit       = 1'b1;
              emit_kind  = KIND_FIRED;
              emit_slot  = SLOT_ID_W'(pend_slot_r);
              emit_event = pend_event_r;
            end
            pend_valid_nxt = 1'b1;
            pend_slot_nxt  = idx_r;
            pend_event_nxt = event_r[idx_r];
            state_nxt      = S_REARM;
          end else if (idx_r == LAST_IDX) begin
            state_nxt = S_FINISH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_REARM: begin
        // one-shot stops, periodic gets now + period
        if (period_r[idx_r] == '0) begin
          st_we = 1'b1;
        end else begin
          dl_we = 1'b1;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_FINISH: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        if (pend_valid_r) begin
          emit_kind  = KIND_FIRED;
          emit_slot  = SLOT_ID_W'(pend_slot_r);
          emit_event = pend_event_r;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      now_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      now_r        <= now_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= emit;
    end
  end

  // command capture, pending fired word and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      id_r  <= in_timer_id;
      dur_r <= in_duration;
      rep_r <= in_repeat_flag;
      ev_r  <= in_event_id;
    end
    pend_slot_r  <= pend_slot_nxt;
    pend_event_r <= pend_event_nxt;
    if (emit) begin
      out_kind_r   <= emit_kind;
      out_slot_r   <= emit_slot;
      out_event_r  <= emit_event;
      out_failed_r <= emit_failed;
      out_last_r   <= emit_last;
    end
  end

  // slot status and deadline, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        status_r[i]   <= ST_UNASSIGNED;
        deadline_r[i] <= '0;
      end
    end else begin
      if (st_we) begin
        status_r[wr_idx] <= st_wdata;
      end
      if (dl_we) begin
        deadline_r[wr_idx] <= alu_sum[DATA_W-1:0];
      end
    end
  end

  // period and event, written by start
  always_ff @(posedge clk) begin
    if (arm_we) begin
      period_r[wr_idx] <= rep_r ? dur_r : '0;
      event_r[wr_idx]  <= ev_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_slot_id         = out_slot_r;
  assign out_fired_event     = out_event_r;
  assign out_register_failed = out_failed_r;
  assign out_system_time     = now_r;
  assign out_last            = out_last_r;

endmodule

@@ design/tst_addsub.sv @@
// ----------------------------------------------------------------------------
// tst_addsub: shared 16-bit add/subtract unit
// Gives a + b, or a - b with the carry out set when a >= b (unsigned).
// ----------------------------------------------------------------------------
module tst_addsub import tst_pkg::*; (
  input  addsub_req_t     req,
  output logic [DATA_W:0] sum
);

  logic [DATA_W-1:0] b_op;

  // invert b for subtract, carry in supplies the +1
  assign b_op = req.sub ? ~req.b : req.b;
  assign sum  = {1'b0, req.a} + {1'b0, b_op} + (DATA_W+1)'(req.sub);

endmodule

@@ design/tst_checker.sv @@
// ----------------------------------------------------------------------------
// tst_checker: port-level checks for the timer slot table
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module tst_checker import tst_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic [KIND_W-1:0]    out_result_kind,
  input logic [SLOT_ID_W-1:0] out_slot_id,
  input logic [DATA_W-1:0]    out_fired_event,
  input logic                 out_register_failed,
  input logic                 out_last
);

  // a taken command keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low after a command was taken");

  // more words still owed means the command is not finished
  a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final word while the block is idle");

  // register and acknowledge always come as a single final word
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_REGISTER || out_result_kind == KIND_ACK)
    |-> out_last)
    else $error("register or acknowledge word not marked last");

  // acknowledge carries no slot and no event
  a_ack_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_ACK
    |-> out_slot_id == '0 && out_fired_event == '0 && !out_register_failed)
    else $error("acknowledge word carries data");

  // failure is only reported by a register answer with slot zero
  a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_register_failed
    |-> out_result_kind == KIND_REGISTER && out_slot_id == '0)
    else $error("register failure in a malformed word");

endmodule

bind timer_slot_table tst_checker u_tst_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_result_kind     (out_result_kind),
  .out_slot_id         (out_slot_id),
  .out_fired_event     (out_fired_event),
  .out_register_failed (out_register_failed),
  .out_last            (out_last)
);

@@ test/timer_slot_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_slot_table_tb: self-checking bench for the timer slot table
// Commands go in through the start/busy handshake from a queue filled up
// front. Each accepted command runs through a local model of the slot table,
// and the result words it predicts are checked in order against out_ words.
// Full-range durations put deadlines just behind the tick counter.
// ----------------------------------------------------------------------------
module timer_slot_table_tb;
  import tst_pkg::*;

  localparam int NUM_TIMERS    = 8;
  localparam int EXPIRY_WINDOW = 32768;
  localparam int SLOTS         = (NUM_TIMERS < ADDRESSABLE) ? NUM_TIMERS : ADDRESSABLE;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct {
    logic [CMD_W-1:0]     command;
    logic [SLOT_ID_W-1:0] timer_id;
    logic [DATA_W-1:0]    duration;
    logic                 repeat_flag;
    logic [DATA_W-1:0]    event_id;
    int unsigned          gap_after;
  } cmd_word_t;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [DATA_W-1:0]    fired_event;
    logic                 register_failed;
    logic [DATA_W-1:0]    system_time;
    logic                 last;
  } result_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     in_command = CMD_TICK;
  logic [SLOT_ID_W-1:0] in_timer_id = '0;
  logic [DATA_W-1:0]    in_duration = '0;
  logic                 in_repeat_flag = 1'b0;
  logic [DATA_W-1:0]    in_event_id = '0;
  logic                 out_valid;
  logic [KIND_W-1:0]    out_result_kind;
  logic [SLOT_ID_W-1:0] out_slot_id;
  logic [DATA_W-1:0]    out_fired_event;
  logic                 out_register_failed;
  logic [DATA_W-1:0]    out_system_time;
  logic                 out_last;

  // commands waiting to go in, and words the table still owes us
  cmd_word_t    pending_cmds[$];
  result_word_t expected_words[$];

  // local copy of the table
  logic [DATA_W-1:0]   model_now;
  logic [STATUS_W-1:0] slot_state[ADDRESSABLE];
  logic [DATA_W-1:0]   slot_deadline[ADDRESSABLE];
  logic [DATA_W-1:0]   slot_period[ADDRESSABLE];
  logic [DATA_W-1:0]   slot_event[ADDRESSABLE];

  int unsigned mismatch_count  = 0;
  int unsigned accepted_count  = 0;
  int unsigned fired_seen      = 0;
  int unsigned reg_fail_seen   = 0;
  int unsigned stall_cycles    = 0;

  timer_slot_table #(
    .NUM_TIMERS    (NUM_TIMERS),
    .EXPIRY_WINDOW (EXPIRY_WINDOW)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_timer_id         (in_timer_id),
    .in_duration         (in_duration),
    .in_repeat_flag      (in_repeat_flag),
    .in_event_id         (in_event_id),
    .out_valid           (out_valid),
    .out_result_kind     (out_result_kind),
    .out_slot_id         (out_slot_id),
    .out_fired_event     (out_fired_event),
    .out_register_failed (out_register_failed),
    .out_system_time     (out_system_time),
    .out_last            (out_last)
  );

  // clock
  always #4 clk = ~clk;

  function automatic result_word_t make_word(logic [KIND_W-1:0] kind,
                                             logic [SLOT_ID_W-1:0] slot,
                                             logic [DATA_W-1:0] ev,
                                             logic failed);
    result_word_t w;
    w.kind            = kind;
    w.slot_id         = slot;
    w.fired_event     = ev;
    w.register_failed = failed;
    w.system_time     = model_now;
    w.last            = 1'b0;
    return w;
  endfunction

  // run one command through the table model and queue the words it yields
  function automatic void apply_command(cmd_word_t c);
    result_word_t      batch[ADDRESSABLE];
    result_word_t      w;
    int                n;
    logic              found;
    logic [DATA_W-1:0] diff;
    n = 0;
    found = 1'b0;
    case (c.command)
      CMD_REGISTER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && slot_state[i] == ST_UNASSIGNED) begin
            slot_state[i] = ST_STOPPED;
            batch[0] = make_word(KIND_REGISTER, i[SLOT_ID_W-1:0], '0, 1'b0);
            found = 1'b1;
          end
        end
        if (!found) batch[0] = make_word(KIND_REGISTER, '0, '0, 1'b1);
        n = 1;
      end
      CMD_TICK: begin
        model_now = model_now + 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_state[i] == ST_RUNNING) begin
            diff = model_now - slot_deadline[i];
            // fires only inside the window and not before the deadline
            if (int'(diff) < EXPIRY_WINDOW && model_now >= slot_deadline[i]) begin
              batch[n] = make_word(KIND_FIRED, i[SLOT_ID_W-1:0], slot_event[i], 1'b0);
              n++;
              if (slot_period[i] == '0) begin
                slot_state[i] = ST_STOPPED;
                slot_event[i] = '0;
              end else begin
                slot_deadline[i] = model_now + slot_period[i];
              end
            end
          end
        end
        if (n == 0) begin
          batch[0] = make_word(KIND_ACK, '0, '0, 1'b0);
          n = 1;
        end
      end
      default: begin
        // start and stop: out-of-range slots are ignored
        if (int'(c.timer_id) < SLOTS) begin
          if (c.command == CMD_START) begin
            if (slot_state[c.timer_id] == ST_STOPPED) begin
              slot_deadline[c.timer_id] = c.duration + model_now;
              slot_period[c.timer_id]   = c.repeat_flag ? c.duration : '0;
              slot_event[c.timer_id]    = c.event_id;
              slot_state[c.timer_id]    = ST_RUNNING;
            end
          end else begin
            slot_state[c.timer_id] = ST_STOPPED;
            slot_event[c.timer_id] = '0;
          end
        end
        batch[0] = make_word(KIND_ACK, '0, '0, 1'b0);
        n = 1;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      w = batch[i];
      w.last = (i == n - 1);
      expected_words.push_back(w);
    end
  endfunction

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  function automatic logic [DATA_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      6, 7:    return DATA_W'($urandom);
      8:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      9:       return DATA_W'(16'hFFFF - $urandom_range(0, 24));
      default: return DATA_W'($urandom_range(0, 24));
    endcase
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [SLOT_ID_W-1:0] id,
                           logic [DATA_W-1:0] dur, logic rep,
                           logic [DATA_W-1:0] ev, int unsigned gap);
    cmd_word_t c;
    c.command     = cmd;
    c.timer_id    = id;
    c.duration    = dur;
    c.repeat_flag = rep;
    c.event_id    = ev;
    c.gap_after   = gap;
    pending_cmds.push_back(c);
  endtask

  // random command, weighted toward starts and ticks
  task automatic queue_random(int unsigned gap);
    int unsigned      roll;
    logic [CMD_W-1:0] cmd;
    roll = $urandom_range(0, 99);
    if (roll < 10)      cmd = CMD_REGISTER;
    else if (roll < 45) cmd = CMD_START;
    else if (roll < 60) cmd = CMD_STOP;
    else                cmd = CMD_TICK;
    queue_cmd(cmd, SLOT_ID_W'($urandom_range(0, 7)), pick_duration(),
              1'($urandom_range(0, 1)), DATA_W'($urandom_range(0, 65535)), gap);
  endtask

  // driver: hold a word until taken, then idle or send the next one
  int unsigned gap_left = 0;
  cmd_word_t   active_cmd;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_command(active_cmd);
        accepted_count++;
      end
      if (!(start && busy)) begin
        if (gap_left != 0 || pending_cmds.size() == 0) begin
          if (gap_left != 0) gap_left--;
          start          <= 1'b0;
          in_command     <= CMD_W'($urandom);
          in_timer_id    <= SLOT_ID_W'($urandom);
          in_duration    <= DATA_W'($urandom);
          in_repeat_flag <= 1'($urandom);
          in_event_id    <= DATA_W'($urandom);
        end else begin
          active_cmd = pending_cmds.pop_front();
          gap_left   = active_cmd.gap_after;
          start          <= 1'b1;
          in_command     <= active_cmd.command;
          in_timer_id    <= active_cmd.timer_id;
          in_duration    <= active_cmd.duration;
          in_repeat_flag <= active_cmd.repeat_flag;
          in_event_id    <= active_cmd.event_id;
        end
      end
    end
  end

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // monitor: every result word against the oldest expected one
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing outstanding: kind %0d slot %0d time %0d",
               out_result_kind, out_slot_id, out_system_time);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("result_kind", DATA_W'(want.kind), DATA_W'(out_result_kind));
        check_field("slot_id", DATA_W'(want.slot_id), DATA_W'(out_slot_id));
        check_field("fired_event", want.fired_event, out_fired_event);
        check_field("register_failed", DATA_W'(want.register_failed),
                    DATA_W'(out_register_failed));
        check_field("system_time", want.system_time, out_system_time);
        check_field("last", DATA_W'(want.last), DATA_W'(out_last));
        if (want.kind == KIND_FIRED) fired_seen++;
        if (want.register_failed) reg_fail_seen++;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    model_now = '0;
    for (int i = 0; i < ADDRESSABLE; i++) begin
      slot_state[i]    = ST_UNASSIGNED;
      slot_deadline[i] = '0;
      slot_period[i]   = '0;
      slot_event[i]    = '0;
    end

    // start on an unassigned slot is ignored, stop on one claims it
    queue_cmd(CMD_START, 3, 5, 1'b1, 16'h00AA, pick_gap());
    queue_cmd(CMD_STOP, 6, 0, 1'b0, 0, pick_gap());
    // claim every slot, then the table is full
    for (int i = 0; i < 8; i++) queue_cmd(CMD_REGISTER, 0, 0, 1'b0, 0, pick_gap());
    queue_cmd(CMD_REGISTER, 7, 16'hFFFF, 1'b1, 16'hFFFF, pick_gap());
    // zero duration one-shot, zero duration with repeat, short periodic
    queue_cmd(CMD_START, 0, 0, 1'b0, 16'hFFFF, pick_gap());
    queue_cmd(CMD_START, 1, 0, 1'b1, 16'h8001, pick_gap());
    queue_cmd(CMD_START, 2, 1, 1'b1, 16'h0000, pick_gap());
    queue_cmd(CMD_START, 3, 2, 1'b0, 16'h5A5A, pick_gap());
    // full duration wraps the deadline just behind now
    queue_cmd(CMD_START, 4, 16'hFFFF, 1'b1, 16'hA5A5, pick_gap());
    // start on a running slot is ignored
    queue_cmd(CMD_START, 2, 16'h7FFF, 1'b0, 16'h1111, pick_gap());
    for (int i = 0; i < 3; i++) queue_cmd(CMD_TICK, 0, 0, 1'b0, 0, pick_gap());
    queue_cmd(CMD_STOP, 2, 0, 1'b0, 0, pick_gap());
    queue_cmd(CMD_STOP, 4, 0, 1'b0, 0, pick_gap());
    queue_cmd(CMD_STOP, 7, 0, 1'b0, 0, pick_gap());
    queue_cmd(CMD_TICK, 5, 16'hFFFF, 1'b1, 16'hFFFF, pick_gap());

    // random mix, with a stretch of back-to-back words in the middle
    for (int k = 0; k < 90; k++) queue_random((k >= 30 && k < 50) ? 0 : pick_gap());

    // long timers armed before the second mix
    for (int i = 0; i < 5; i++) queue_cmd(CMD_STOP, SLOT_ID_W'(i), 0, 1'b0, 0, pick_gap());
    queue_cmd(CMD_START, 0, 40000, 1'b1, 16'h1234, 0);
    queue_cmd(CMD_START, 1, 65000, 1'b0, 16'hFFFE, 0);
    queue_cmd(CMD_START, 2, 30000, 1'b1, 16'h0001, 0);
    queue_cmd(CMD_START, 3, 997, 1'b1, 16'h4321, 0);
    queue_cmd(CMD_START, 4, 50000, 1'b1, 16'hBEEF, 0);

    // second random mix, no idling in the last part
    for (int k = 0; k < 90; k++) queue_random((k >= 50) ? 0 : pick_gap());

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_cmds.size() != 0 || start || expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands through the slot table, including a full table",
             accepted_count);
    $display("Saw %0d timer expiries and %0d failed registers", fired_seen, reg_fail_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/tst_pkg.sv
design/tst_addsub.sv
design/timer_slot_table.sv
design/tst_checker.sv
test/timer_slot_table_tb.sv
